FILE: rtl/sfdu_pkg.sv
// Shared codes, character constants and types for the SFDU marker stack tracker.
package sfdu_pkg;

  // ASCII bytes that steer the label handling.
  localparam logic [7:0] CH_VER3 = 8'h33;  // '3'
  localparam logic [7:0] CH_S    = 8'h53;  // 'S'
  localparam logic [7:0] CH_E    = 8'h45;  // 'E'
  localparam logic [7:0] CH_F    = 8'h46;  // 'F'
  localparam logic [7:0] CH_Z    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_U    = 8'h55;  // 'U'
  localparam logic [7:0] CH_R    = 8'h52;  // 'R'
  localparam logic [7:0] CH_C    = 8'h43;  // 'C'
  localparam logic [7:0] CH_I    = 8'h49;  // 'I'
  localparam logic [7:0] CH_D    = 8'h44;  // 'D'
  localparam logic [7:0] CH_K    = 8'h4B;  // 'K'
  localparam logic [7:0] CH_V    = 8'h56;  // 'V'

  // Reset value of the routing authority register.
  localparam logic [31:0] AUTH_RESET = 32'h4E4A504C;

  localparam int DEFAULT_STACK_DEPTH = 8;

  // Stack event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_PUSH = 2'd1;
  localparam logic [1:0] EV_POP  = 2'd2;
  localparam logic [1:0] EV_ERR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_EOD    = 2'd1;
  localparam logic [1:0] ST_APP    = 2'd2;
  localparam logic [1:0] ST_CAT    = 2'd3;

  // Class list positions.
  localparam logic [3:0] CLS_Z       = 4'd0;
  localparam logic [3:0] CLS_U       = 4'd1;
  localparam logic [3:0] CLS_F       = 4'd2;
  localparam logic [3:0] CLS_R       = 4'd3;
  localparam logic [3:0] CLS_C       = 4'd4;
  localparam logic [3:0] CLS_I       = 4'd5;
  localparam logic [3:0] CLS_S       = 4'd6;
  localparam logic [3:0] CLS_D       = 4'd7;
  localparam logic [3:0] CLS_E       = 4'd8;
  localparam logic [3:0] CLS_K       = 4'd9;
  localparam logic [3:0] CLS_V       = 4'd10;
  localparam logic [3:0] CLS_UNKNOWN = 4'd11;

  // Outcome of one label on the marker stack.
  typedef struct packed {
    logic [1:0] ev;      // stack event code
    logic       empty;   // stack is empty after this label
    logic [3:0] level;   // stack level after this label, low four bits
  } stk_res_t;

  function automatic logic [3:0] class_lookup(input logic [7:0] c);
    logic [3:0] idx;
    case (c)
      CH_Z:    idx = CLS_Z;
      CH_U:    idx = CLS_U;
      CH_F:    idx = CLS_F;
      CH_R:    idx = CLS_R;
      CH_C:    idx = CLS_C;
      CH_I:    idx = CLS_I;
      CH_S:    idx = CLS_S;
      CH_D:    idx = CLS_D;
      CH_E:    idx = CLS_E;
      CH_K:    idx = CLS_K;
      CH_V:    idx = CLS_V;
      default: idx = CLS_UNKNOWN;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/sfdu_stack.sv
// Marker stack: level counter, top and bottom copies, and the entry memory.
module sfdu_stack
  import sfdu_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  version,
  input  logic [7:0]  delimiter,
  input  logic [63:0] marker,
  output stk_res_t    res
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [63:0]       mem [0:STACK_DEPTH-1];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_eff;
  logic [63:0]       top;
  logic [63:0]       top_next;
  logic [63:0]       bottom;
  logic [63:0]       bottom_next;
  logic [63:0]       below;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W+3:0]  level_ext;
  logic              is_v3;
  logic              is_ef;
  logic              top_hit;
  logic              bot_hit;
  logic [1:0]        ev;

  assign is_v3   = (version == CH_VER3);
  assign is_ef   = (delimiter == CH_E) || (delimiter == CH_F);
  assign top_hit = (marker == top);
  assign bot_hit = (delimiter == CH_F) && (marker == bottom);
  assign wr_addr = count[ADDR_W-1:0];

  always_comb begin
    count_next  = count;
    top_next    = top;
    bottom_next = bottom;
    wr_en       = 1'b0;
    ev          = EV_NONE;
    if (is_v3 && is_ef) begin
      if (count == '0) begin
        ev = EV_ERR;
      end else if (bot_hit) begin
        count_next = '0;
        ev         = EV_POP;
      end else if (top_hit) begin
        count_next = count - CNT_W'(1);
        top_next   = below;
        ev         = EV_POP;
      end else begin
        ev = EV_ERR;
      end
    end else if (is_v3 && (delimiter == CH_S)) begin
      if (count == CNT_W'(STACK_DEPTH)) begin
        ev = EV_ERR;
      end else begin
        wr_en      = 1'b1;
        count_next = count + CNT_W'(1);
        top_next   = marker;
        if (count == '0) begin
          bottom_next = marker;
        end
        ev = EV_PUSH;
      end
    end
  end

  // The entry just under the new top is fetched every cycle so that a pop
  // finds it ready as the next top.
  always_comb begin
    count_eff = advance ? count_next : count;
    rd_idx    = count_eff - CNT_W'(2);
    rd_addr   = (count_eff >= CNT_W'(2)) ? rd_idx[ADDR_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      mem[wr_addr] <= marker;
    end
    below <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      top    <= top_next;
      bottom <= bottom_next;
    end
  end

  assign level_ext = {4'b0000, count_next};

  always_comb begin
    res.ev    = ev;
    res.empty = (count_next == '0);
    res.level = level_ext[3:0];
  end

endmodule

FILE: rtl/sfdu_classify.sv
// Label classification: class position, structure flag and routing status.
module sfdu_classify
  import sfdu_pkg::*;
(
  input  logic [7:0]  delimiter,
  input  logic [7:0]  class_id,
  input  logic [31:0] authority,
  input  logic [31:0] authority_id,
  input  stk_res_t    stk,
  output logic [1:0]  status,
  output logic        structure_unpushed,
  output logic [3:0]  class_index
);

  logic is_struct;
  logic is_ef;

  assign class_index = class_lookup(class_id);
  assign is_struct   = (class_id == CH_Z) || (class_id == CH_U) || (class_id == CH_F);
  assign is_ef       = (delimiter == CH_E) || (delimiter == CH_F);
  assign structure_unpushed = is_struct && (stk.ev != EV_PUSH);

  // End of data wins over routing.
  always_comb begin
    status = ST_NORMAL;
    if (is_ef && stk.empty) begin
      status = ST_EOD;
    end else if (authority == authority_id) begin
      if (class_id == CH_I) begin
        status = ST_APP;
      end else if (class_id == CH_K) begin
        status = ST_CAT;
      end
    end
  end

endmodule

FILE: rtl/sfdu_marker_stack_tracker_unit.sv
// Top level of the SFDU marker stack tracker: label register, stack, result register.
//
//  Channel   Direction  Signals                           Payload
//  s_axis    in         s_axis_tvalid/tready/tdata[119:0] one decoded label request
//  m_axis    out        m_axis_tvalid/tready/tdata[15:0]  one result per label
//  cfg       in         cfg_valid/cfg_ready/cfg_data[31:0] routing authority register
//
// Every label request gives exactly one result: it waits in the label register,
// then the stack update and classification settle in one combinational step
// into the result register. Sustained rate is one label per cycle while m_axis
// is not stalled; the loop that sets it is the stack level and top/bottom
// registers, which are read and rewritten in the same cycle. Reset (rst,
// synchronous, active high) empties the stack and loads the default authority;
// the stack entries themselves are not cleared. A stall on m_axis holds the
// result register and, one request later, the label register; s_axis_tready
// then drops until the result is taken.
module sfdu_marker_stack_tracker_unit
  import sfdu_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  // Label requests.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: version[7:0], delimiter[15:8], class_id[23:16],
  // marker[87:24], authority[119:88].
  input  logic [119:0] s_axis_tdata,
  // Results.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: status[1:0], stack_event[3:2], structure_unpushed[4],
  // class_index[8:5], stack_level[12:9], zero[15:13].
  output logic [15:0]  m_axis_tdata,
  // Authority register writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  // Label register.
  logic        in_valid;
  logic [7:0]  version;
  logic [7:0]  delimiter;
  logic [7:0]  class_id;
  logic [63:0] marker;
  logic [31:0] authority;

  // Routing authority register.
  logic [31:0] authority_id;

  // Result register.
  logic        out_valid;
  logic [1:0]  status;
  logic [1:0]  stack_event;
  logic        structure_unpushed;
  logic [3:0]  class_index;
  logic [3:0]  stack_level;

  // Combinational results for the label in the label register.
  stk_res_t    stk;
  logic [1:0]  status_next;
  logic        unpushed_next;
  logic [3:0]  class_index_next;

  logic        move;
  logic        take;

  // The label leaves its register whenever the result register is free or
  // being emptied in the same cycle; the stack commits only then.
  assign move          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      version   <= s_axis_tdata[7:0];
      delimiter <= s_axis_tdata[15:8];
      class_id  <= s_axis_tdata[23:16];
      marker    <= s_axis_tdata[87:24];
      authority <= s_axis_tdata[119:88];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      authority_id <= AUTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      authority_id <= cfg_data;
    end
  end

  sfdu_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .advance   (move),
    .version   (version),
    .delimiter (delimiter),
    .marker    (marker),
    .res       (stk)
  );

  sfdu_classify u_classify (
    .delimiter          (delimiter),
    .class_id           (class_id),
    .authority          (authority),
    .authority_id       (authority_id),
    .stk                (stk),
    .status             (status_next),
    .structure_unpushed (unpushed_next),
    .class_index        (class_index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status             <= status_next;
      stack_event        <= stk.ev;
      structure_unpushed <= unpushed_next;
      class_index        <= class_index_next;
      stack_level        <= stk.level;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, stack_level, class_index, structure_unpushed,
                          stack_event, status};

  // A held label is never dropped while it waits for the result register.
  a_label_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !move |=> in_valid)
    else $error("label register lost a waiting request");

  // With the result register empty, the block must be open for a new label.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

  // Every committed label shows up as a result in the next cycle.
  a_move_gives_result: assert property (@(posedge clk) disable iff (rst)
    move |=> m_axis_tvalid)
    else $error("committed label produced no result");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the SFDU marker stack tracker: directed labels, then random ones.
module testbench;
  import sfdu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
  localparam int PHASE_ITEMS = 288;
  localparam int HOLD_CYCLES = 400;

  // Delimiter and version bytes that the package has no name for.
  localparam logic [7:0] DELIM_A = "A";
  localparam logic [7:0] DELIM_B = "B";
  localparam logic [7:0] DELIM_C = "C";
  localparam logic [7:0] VER_OTHER = "2";

  // Class bytes in list order; the position in this list is the class index.
  localparam logic [7:0] CLASS_ORDER [0:10] =
    '{CH_Z, CH_U, CH_F, CH_R, CH_C, CH_I, CH_S, CH_D, CH_E, CH_K, CH_V};

  // Markers for the directed part, all different from each other.
  localparam logic [63:0] MK_BOT = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] MK_B   = 64'h8000_0000_0000_0001;
  localparam logic [63:0] MK_C   = 64'h5555_AAAA_5555_AAAA;
  localparam logic [63:0] MK_D   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MK_E   = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] MK_TOP = 64'h7FFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] MK_X   = 64'h5A5A_0F0F_3C3C_9696;

  // One label request, laid out as on s_axis_tdata (version in the lowest byte).
  typedef struct packed {
    logic [31:0] authority;
    logic [63:0] marker;
    logic [7:0]  class_id;
    logic [7:0]  delimiter;
    logic [7:0]  version;
  } sfdu_label_t;

  // One result, laid out as on m_axis_tdata (status in the lowest bits).
  typedef struct packed {
    logic [2:0] pad;
    logic [3:0] level;
    logic [3:0] class_idx;
    logic       unpushed;
    logic [1:0] ev;
    logic [1:0] status;
  } label_result_t;

  // A row of the directed table; typed rows carry a hand-written result.
  typedef struct {
    sfdu_label_t   lbl;
    bit            typed;
    label_result_t res;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  // Shadow copy of the block state, advanced once per accepted label.
  logic [63:0]   shadow_markers [0:STACK_DEPTH-1];
  int            shadow_depth = 0;
  logic [31:0]   shadow_authority = AUTH_RESET;

  label_result_t pending_results [$];
  plan_row_t     plan [$];
  int            mismatches = 0;

  // Idling percentages of the current phase, and the request count for a long
  // receiver hold-off, which the receiver process turns into its own countdown.
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            hold_req = 0;

  sfdu_marker_stack_tracker_unit #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; a correct run ends far earlier.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Works out the result of one label and advances the shadow stack. Only the
  // version-3 labels touch the stack; E or F leaving the stack empty always
  // reports end of data, which wins over routing by authority.
  function automatic label_result_t track_label(input sfdu_label_t l);
    label_result_t r;
    logic          top_hit;
    logic          bot_hit;
    logic          pop_kind;
    r = '0;
    r.ev = EV_NONE;
    r.status = ST_NORMAL;
    pop_kind = (l.delimiter == CH_E) || (l.delimiter == CH_F);
    if (l.version == CH_VER3) begin
      if (pop_kind) begin
        if (shadow_depth == 0) begin
          r.ev = EV_ERR;
        end else begin
          top_hit = (l.marker == shadow_markers[shadow_depth-1]);
          bot_hit = (l.delimiter == CH_F) && (l.marker == shadow_markers[0]);
          if (bot_hit) begin
            shadow_depth = 0;
            r.ev = EV_POP;
          end else if (top_hit) begin
            shadow_depth--;
            r.ev = EV_POP;
          end else begin
            r.ev = EV_ERR;
          end
        end
      end else if (l.delimiter == CH_S) begin
        // A push onto a full stack is an error and leaves the stack as it is.
        if (shadow_depth >= STACK_DEPTH) begin
          r.ev = EV_ERR;
        end else begin
          shadow_markers[shadow_depth] = l.marker;
          shadow_depth++;
          r.ev = EV_PUSH;
        end
      end
    end
    r.unpushed = ((l.class_id == CH_Z) || (l.class_id == CH_U) || (l.class_id == CH_F)) &&
                 (r.ev != EV_PUSH);
    if (pop_kind && shadow_depth == 0) begin
      r.status = ST_EOD;
    end else if (l.authority == shadow_authority) begin
      if (l.class_id == CH_I) begin
        r.status = ST_APP;
      end else if (l.class_id == CH_K) begin
        r.status = ST_CAT;
      end
    end
    r.class_idx = CLS_UNKNOWN;
    for (int k = 10; k >= 0; k--) begin
      if (CLASS_ORDER[k] == l.class_id) begin
        r.class_idx = 4'(k);
      end
    end
    r.level = 4'(shadow_depth);
    return r;
  endfunction

  // Random label. Most are well-formed stack traffic: pushes, pops that match
  // the top, F labels that match the bottom, pushes onto a full stack. The
  // rest are broken pops, other delimiters and versions, and plain noise.
  function automatic sfdu_label_t next_label();
    sfdu_label_t l;
    int          pick;
    l.version = CH_VER3;
    l.class_id = ($urandom_range(99) < 80) ? CLASS_ORDER[$urandom_range(10)] : 8'($urandom);
    l.authority = $urandom_range(1) ? shadow_authority : $urandom;
    l.marker = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 80) begin
      if (shadow_depth == 0 || (shadow_depth < STACK_DEPTH && $urandom_range(99) < 60)) begin
        l.delimiter = CH_S;
        // Reusing a marker already on the stack can make top and bottom coincide.
        if (shadow_depth > 0 && $urandom_range(4) == 0) begin
          l.marker = shadow_markers[$urandom_range(shadow_depth-1)];
        end
      end else if (shadow_depth == STACK_DEPTH && $urandom_range(3) == 0) begin
        l.delimiter = CH_S;
      end else begin
        l.delimiter = $urandom_range(1) ? CH_E : CH_F;
        if (l.delimiter == CH_F && $urandom_range(7) == 0) begin
          l.marker = shadow_markers[0];
        end else begin
          l.marker = shadow_markers[shadow_depth-1];
        end
      end
    end else if (pick < 92) begin
      case ($urandom_range(3))
        0: l.delimiter = CH_E;
        1: l.delimiter = CH_F;
        2: l.delimiter = $urandom_range(1) ? DELIM_A : ($urandom_range(1) ? DELIM_B : DELIM_C);
        default: l.delimiter = 8'($urandom);
      endcase
      if ($urandom_range(2) == 0) begin
        l.version = $urandom_range(1) ? VER_OTHER : 8'($urandom);
      end
    end else begin
      l.version = 8'($urandom);
      l.delimiter = 8'($urandom);
      l.class_id = 8'($urandom);
      l.authority = $urandom;
    end
    return l;
  endfunction

  function automatic plan_row_t label_row(input logic [7:0] ver, input logic [7:0] del,
                                          input logic [7:0] cls, input logic [63:0] mk,
                                          input logic [31:0] auth, input bit typed,
                                          input logic [1:0] st, input logic [1:0] ev,
                                          input logic up, input logic [3:0] ci,
                                          input logic [3:0] lvl);
    plan_row_t p;
    p.lbl = '{authority: auth, marker: mk, class_id: cls, delimiter: del, version: ver};
    p.typed = typed;
    p.res = '{pad: 3'd0, level: lvl, class_idx: ci, unpushed: up, ev: ev, status: st};
    return p;
  endfunction

  // Offers one label request after a random gap and waits until it is taken.
  // Valid stays high between back-to-back requests.
  task automatic offer_label(input sfdu_label_t l);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= l;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Waits until every expected result is in, then lets the pipeline settle.
  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_authority(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_authority = value;
  endtask

  task automatic compare_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: takes results under random stalls or a long hold-off and checks
  // each one, field by field, against the oldest expected result.
  always @(posedge clk) begin : result_side
    label_result_t want;
    label_result_t got;
    int            hold_seen;
    int            hold_left;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 4'(want.status), 4'(got.status));
        compare_field("stack_event", 4'(want.ev), 4'(got.ev));
        compare_field("structure_unpushed", 4'(want.unpushed), 4'(got.unpushed));
        compare_field("class_index", want.class_idx, got.class_idx);
        compare_field("stack_level", want.level, got.level);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin : stimulus
    sfdu_label_t   lbl;
    label_result_t predicted;
    logic [31:0]   phase_auth [0:3];
    int            phase_tx [0:3];
    int            phase_rx [0:3];

    // Directed table. The stack is filled to the top with markers at both
    // extremes, then overflowed, mismatched and unwound from top and bottom.
    plan.push_back(label_row(CH_VER3, CH_E, CH_Z, MK_X, 32'h0, 1,  // pop of empty stack, E
                             ST_EOD, EV_ERR, 1'b1, CLS_Z, 4'd0));
    plan.push_back(label_row(CH_VER3, CH_F, CH_U, MK_X, 32'h0, 1,  // pop of empty stack, F
                             ST_EOD, EV_ERR, 1'b1, CLS_U, 4'd0));
    plan.push_back(label_row(CH_VER3, CH_S, CH_Z, MK_BOT, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_Z, 4'd1));
    plan.push_back(label_row(CH_VER3, CH_S, CH_U, MK_B, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_U, 4'd2));
    plan.push_back(label_row(CH_VER3, CH_S, CH_F, '1, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_F, 4'd3));
    plan.push_back(label_row(CH_VER3, CH_S, CH_R, '0, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_R, 4'd4));
    plan.push_back(label_row(CH_VER3, CH_S, CH_C, MK_C, AUTH_RESET, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_C, 4'd5));
    plan.push_back(label_row(CH_VER3, CH_S, CH_I, MK_D, AUTH_RESET, 1,
                             ST_APP, EV_PUSH, 1'b0, CLS_I, 4'd6));
    plan.push_back(label_row(CH_VER3, CH_S, CH_K, MK_E, AUTH_RESET, 1,
                             ST_CAT, EV_PUSH, 1'b0, CLS_K, 4'd7));
    plan.push_back(label_row(CH_VER3, CH_S, CH_S, MK_TOP, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_S, 4'd8));
    plan.push_back(label_row(CH_VER3, CH_S, CH_Z, MK_X, 32'h0, 1,  // push onto a full stack
                             ST_NORMAL, EV_ERR, 1'b1, CLS_Z, 4'd8));
    plan.push_back(label_row(CH_VER3, CH_E, CH_D, MK_X, 32'h0, 1,  // E that misses the top
                             ST_NORMAL, EV_ERR, 1'b0, CLS_D, 4'd8));
    plan.push_back(label_row(CH_VER3, CH_E, CH_E, MK_TOP, 32'h0, 1,
                             ST_NORMAL, EV_POP, 1'b0, CLS_E, 4'd7));
    plan.push_back(label_row(CH_VER3, CH_F, CH_V, MK_X, 32'h0, 1,  // F that misses both ends
                             ST_NORMAL, EV_ERR, 1'b0, CLS_V, 4'd7));
    plan.push_back(label_row(CH_VER3, CH_F, CH_K, MK_E, AUTH_RESET, 1,
                             ST_CAT, EV_POP, 1'b0, CLS_K, 4'd6));
    plan.push_back(label_row(CH_VER3, CH_F, CH_I, MK_BOT, AUTH_RESET, 1,  // F on the bottom
                             ST_EOD, EV_POP, 1'b0, CLS_I, 4'd0));
    plan.push_back(label_row(VER_OTHER, CH_E, CH_Z, MK_X, 32'h0, 1,  // other version, empty
                             ST_EOD, EV_NONE, 1'b1, CLS_Z, 4'd0));
    plan.push_back(label_row(VER_OTHER, CH_S, CH_I, MK_X, AUTH_RESET, 1,
                             ST_APP, EV_NONE, 1'b0, CLS_I, 4'd0));
    plan.push_back(label_row(CH_VER3, DELIM_A, CH_K, MK_X, AUTH_RESET, 1,
                             ST_CAT, EV_NONE, 1'b0, CLS_K, 4'd0));
    plan.push_back(label_row(CH_VER3, CH_S, CH_Z, MK_BOT, 32'h0, 1,
                             ST_NORMAL, EV_PUSH, 1'b0, CLS_Z, 4'd1));
    plan.push_back(label_row(CH_VER3, CH_F, CH_Z, MK_BOT, 32'h0, 1,  // top and bottom at once
                             ST_EOD, EV_POP, 1'b1, CLS_Z, 4'd0));
    plan.push_back(label_row(8'hFF, 8'h00, 8'h00, '1, 32'hFFFF_FFFF, 1,
                             ST_NORMAL, EV_NONE, 1'b0, CLS_UNKNOWN, 4'd0));
    plan.push_back(label_row(8'h00, 8'hFF, 8'hFF, '0, 32'h0, 1,
                             ST_NORMAL, EV_NONE, 1'b0, CLS_UNKNOWN, 4'd0));
    plan.push_back(label_row(CH_VER3, CH_S, CH_U, MK_C, AUTH_RESET, 0,
                             ST_NORMAL, EV_NONE, 1'b0, CLS_UNKNOWN, 4'd0));
    plan.push_back(label_row(CH_VER3, CH_E, CH_I, MK_C, AUTH_RESET, 0,
                             ST_NORMAL, EV_NONE, 1'b0, CLS_UNKNOWN, 4'd0));

    // Phases: no idling, sender idle, receiver stalling, both; each under its
    // own authority setting, the all-zero and all-one extremes among them.
    phase_auth[0] = 32'h0;
    phase_auth[1] = 32'hFFFF_FFFF;
    phase_auth[2] = $urandom;
    phase_auth[3] = AUTH_RESET;
    phase_tx[0] = 0;  phase_rx[0] = 0;
    phase_tx[1] = 86; phase_rx[1] = 0;
    phase_tx[2] = 0;  phase_rx[2] = 86;
    phase_tx[3] = 31; phase_rx[3] = 31;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed part runs against the reset value of the authority.
    foreach (plan[i]) begin
      offer_label(plan[i].lbl);
      predicted = track_label(plan[i].lbl);
      pending_results.push_back(plan[i].typed ? plan[i].res : predicted);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      wait_results_drained();
      write_authority(phase_auth[ph]);
      tx_idle_pct = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while requests keep coming: the block fills
        // up and must stall its input without losing anything.
        if (ph == 0 && n == 120) begin
          hold_req <= hold_req + 1;
        end
        // Sender pause until every result is back, with the stack mid-way.
        if (ph == 2 && n == 150) begin
          s_axis_tvalid <= 1'b0;
          wait_results_drained();
        end
        lbl = next_label();
        offer_label(lbl);
        pending_results.push_back(track_label(lbl));
      end
      s_axis_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
